@@ rtl/core/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// Spectral peak picker package
// Shared widths, register codes and the structs that pass between the stages.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int MAG_W       = 24;
  localparam int BIN_W       = 12;
  localparam int MAX_BINS    = 4096;
  localparam int CNT_W       = $clog2(MAX_BINS + 1);
  localparam int PF_W        = CNT_W + 1;
  localparam int LEFT_REACH  = 10;
  localparam int RIGHT_REACH = 9;
  localparam int WIN_DEPTH   = LEFT_REACH + 1 + RIGHT_REACH;
  localparam int REACH_W     = $clog2(LEFT_REACH + 1);
  localparam int RATIO_W     = 16;
  localparam int RATIO_FRAC  = 12;
  localparam int PROD_W      = MAG_W + RATIO_W;

  // valley search tree: candidates, then two pairwise levels in stage 1
  localparam int CAND_N = WIN_DEPTH;
  localparam int LVL1_N = (CAND_N + 1) / 2;
  localparam int LVL2_N = (LVL1_N + 1) / 2;
  localparam int PAD_N  = 8;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROM_RATIO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALLEY_FLOOR   = 2'd2;

  localparam logic [MAG_W-1:0]   RST_PEAK_THRESHOLD = 24'd66;
  localparam logic [RATIO_W-1:0] RST_PROM_RATIO     = 16'd5793;
  localparam logic [MAG_W-1:0]   RST_VALLEY_FLOOR   = 24'd7;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [WIN_DEPTH-1:0][MAG_W-1:0] win_t;

  typedef enum logic [1:0] {
    ST_STREAM,
    ST_FLUSH,
    ST_MARK
  } seq_state_t;

  typedef struct packed {
    mag_t               thr;
    logic [RATIO_W-1:0] ratio;
    mag_t               floor;
  } cfg_t;

  // one judge slot handed from the sequencer to the judge pipeline
  typedef struct packed {
    logic               vld;
    logic               mark;
    logic               pok;
    logic [BIN_W-1:0]   bin;
    logic [REACH_W-1:0] lcnt;
    logic [REACH_W-1:0] rcnt;
  } slot_t;

  typedef struct packed {
    logic s1_vld;
    logic s2_vld;
  } jstat_t;

  typedef struct packed {
    logic             is_peak;
    logic [BIN_W-1:0] bin_index;
    mag_t             peak_magnitude;
    logic             frame_end;
  } res_t;

endpackage

@@ rtl/core/spectral_peak_picker_unit.sv @@
// ----------------------------------------------------------------------------
// Spectral peak picker
// Streams one magnitude bin per transaction and reports prominent peaks.
// ----------------------------------------------------------------------------
// Throughput: one bin per cycle while streaming and the result queue has room;
//   the last bin of a frame adds 8 flush steps through the judge unit and the
//   frame end marker. The report for bin p is decided by the transaction of
//   bin p+9 and passes the window, two judge stages and the result queue.
// Reset: synchronous active-low; clears sequencer, pipeline valids and queue,
//   and loads the default threshold, prominence ratio and valley floor.
module spectral_peak_picker_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spp_pkg::MAG_W-1:0]     in_magnitude,
  input  logic                          in_last_bin,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_peak,
  output logic [spp_pkg::BIN_W-1:0]     out_bin_index,
  output logic [spp_pkg::MAG_W-1:0]     out_peak_magnitude,
  output logic                          out_frame_end,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spp_pkg::*;

  cfg_t               cfg_r;
  win_t               win;
  slot_t              slot;
  jstat_t             jstat;
  logic               push, pop, room;
  res_t               push_data, head;
  logic [FIFO_CW-1:0] fifo_cnt, occ;

  // Configuration: always ready; the user writes only while the block is idle;
  // the block does not enforce this. Writes to the unused index are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr   <= RST_PEAK_THRESHOLD;
      cfg_r.ratio <= RST_PROM_RATIO;
      cfg_r.floor <= RST_VALLEY_FLOOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PEAK_THRESHOLD: cfg_r.thr   <= cfg_data[MAG_W-1:0];
        CFG_PROM_RATIO:     cfg_r.ratio <= cfg_data[RATIO_W-1:0];
        CFG_VALLEY_FLOOR:   cfg_r.floor <= cfg_data[MAG_W-1:0];
        default:            cfg_r       <= cfg_r;
      endcase
    end
  end

  // Flow control: every slot in flight may still produce one result, so a
  // new slot is issued only if the queue can hold all of them. Pops are not
  // counted, which keeps in_stall purely registered.
  assign occ  = fifo_cnt + FIFO_CW'(slot.vld) + FIFO_CW'(jstat.s1_vld)
                + FIFO_CW'(jstat.s2_vld);
  assign room = occ < FIFO_CW'(FIFO_DEPTH);

  // Window shift register, bin counter and flush sequencer.
  spp_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_magnitude (in_magnitude),
    .in_last_bin  (in_last_bin),
    .room         (room),
    .in_stall     (in_stall),
    .win          (win),
    .slot         (slot)
  );

  // Judge: the candidate always sits at the center tap of the window.
  spp_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win),
    .slot      (slot),
    .cfg       (cfg_r),
    .jstat     (jstat),
    .push      (push),
    .push_data (push_data)
  );

  // Result queue decouples the result channel from the judge pipeline.
  assign pop = out_valid && !out_stall;

  spp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign out_valid          = (fifo_cnt != '0);
  assign out_is_peak        = head.is_peak;
  assign out_bin_index      = head.bin_index;
  assign out_peak_magnitude = head.peak_magnitude;
  assign out_frame_end      = head.frame_end;

endmodule

@@ rtl/core/spp_window.sv @@
// ----------------------------------------------------------------------------
// Spectral peak picker bin window and sequencer
// Shifts bins into the window, counts the frame and issues judge slots,
// including the flush steps and the frame end marker after the last bin.
// ----------------------------------------------------------------------------
module spp_window (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [spp_pkg::MAG_W-1:0] in_magnitude,
  input  logic                   in_last_bin,
  input  logic                   room,
  output logic                   in_stall,
  output spp_pkg::win_t          win,
  output spp_pkg::slot_t         slot
);
  import spp_pkg::*;

  seq_state_t         st_r, st_nxt;
  logic [REACH_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  win_t               win_r, win_nxt;
  slot_t              slot_r, slot_nxt;
  logic [PF_W-1:0]    p_full;
  logic               in_acc;

  function automatic slot_t make_slot(logic [PF_W-1:0] p, logic [REACH_W-1:0] rc);
    slot_t s;
    s.vld  = 1'b1;
    s.mark = 1'b0;
    s.pok  = !p[PF_W-1] && (p != '0);
    s.bin  = p[BIN_W-1:0];
    s.lcnt = (p >= PF_W'(LEFT_REACH)) ? REACH_W'(LEFT_REACH) : p[REACH_W-1:0];
    s.rcnt = rc;
    return s;
  endfunction

  assign in_stall = !room || (st_r != ST_STREAM);
  assign in_acc   = in_valid && !in_stall;
  assign win      = win_r;
  assign slot     = slot_r;

  always_comb begin
    st_nxt   = st_r;
    j_nxt    = j_r;
    cnt_nxt  = cnt_r;
    win_nxt  = win_r;
    slot_nxt = '0;
    p_full   = '0;
    case (st_r)
      ST_STREAM: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(MAX_BINS)) begin
            win_nxt  = {in_magnitude, win_r[WIN_DEPTH-1:1]};
            cnt_nxt  = cnt_r + 1'b1;
            p_full   = {1'b0, cnt_r} - PF_W'(RIGHT_REACH);
            slot_nxt = make_slot(p_full, REACH_W'(RIGHT_REACH));
          end
          if (in_last_bin) begin
            st_nxt = ST_FLUSH;
            j_nxt  = REACH_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        // each step moves the next pending bin to the center tap
        if (room) begin
          win_nxt  = {{MAG_W{1'b0}}, win_r[WIN_DEPTH-1:1]};
          p_full   = {1'b0, cnt_r} - PF_W'(LEFT_REACH) + PF_W'(j_r);
          slot_nxt = make_slot(p_full, REACH_W'(RIGHT_REACH) - j_r);
          if (j_r == REACH_W'(RIGHT_REACH - 1)) begin
            st_nxt = ST_MARK;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      ST_MARK: begin
        if (room) begin
          slot_nxt.vld  = 1'b1;
          slot_nxt.mark = 1'b1;
          cnt_nxt       = '0;
          st_nxt        = ST_STREAM;
        end
      end
      default: begin
        st_nxt = ST_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_STREAM;
      j_r    <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else begin
      st_r   <= st_nxt;
      j_r    <= j_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

`ifndef NO_ASSERTIONS
  a_flush_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FLUSH) |-> (j_r != '0 && j_r <= REACH_W'(RIGHT_REACH - 1)))
    else $error("flush step out of range");
  a_right_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r.vld && !slot_r.mark) |-> (slot_r.rcnt != '0))
    else $error("judge slot without a right neighbor");
  a_mark_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r.vld && slot_r.mark) |-> (st_r == ST_STREAM && cnt_r == '0))
    else $error("frame end marker issued without frame reset");
`endif

endmodule

@@ rtl/core/spp_judge.sv @@
// ----------------------------------------------------------------------------
// Spectral peak picker judge pipeline
// Local maximum and threshold test, valley walk and min tree, then the
// floor test and the prominence ratio compare.
// ----------------------------------------------------------------------------
module spp_judge (
  input  logic           clk,
  input  logic           rst_n,
  input  spp_pkg::win_t  win,
  input  spp_pkg::slot_t slot,
  input  spp_pkg::cfg_t  cfg,
  output spp_pkg::jstat_t jstat,
  output logic           push,
  output spp_pkg::res_t  push_data
);
  import spp_pkg::*;

  typedef struct packed {
    logic                         vld;
    logic                         mark;
    logic                         lm;
    logic [BIN_W-1:0]             bin;
    mag_t                         mag;
    logic [LVL2_N-1:0][MAG_W-1:0] mins;
  } s1_t;

  typedef struct packed {
    logic             vld;
    logic             mark;
    logic             ok;
    logic [BIN_W-1:0] bin;
    mag_t             mag;
    mag_t             valley;
  } s2_t;

  function automatic mag_t min2(mag_t a, mag_t b);
    return (b < a) ? b : a;
  endfunction

  mag_t                  mag;
  logic [LEFT_REACH-1:0]  lrise, lgo;
  logic [RIGHT_REACH-1:0] rrise, rgo;
  mag_t                  cand [CAND_N];
  mag_t                  lvl1 [LVL1_N];
  mag_t                  pad  [PAD_N];
  mag_t                  t4   [PAD_N/2];
  mag_t                  t2   [PAD_N/4];
  s1_t                   s1_r, s1_nxt;
  s2_t                   s2_r, s2_nxt;
  logic [PROD_W-1:0]     prod, lhs;
  logic                  pass;

  // stage 1: walks as prefix masks over the rise flags, first tree levels
  always_comb begin
    mag     = win[LEFT_REACH];
    cand[0] = mag;
    for (int k = 1; k <= LEFT_REACH; k++) begin
      lrise[k-1] = win[LEFT_REACH-k] > win[LEFT_REACH-k+1];
    end
    for (int k = 1; k <= RIGHT_REACH; k++) begin
      rrise[k-1] = win[LEFT_REACH+k] > win[LEFT_REACH+k-1];
    end
    lgo[0] = 1'b1;
    for (int k = 1; k < LEFT_REACH; k++) begin
      lgo[k] = lgo[k-1] && !lrise[k-1];
    end
    rgo[0] = 1'b1;
    for (int k = 1; k < RIGHT_REACH; k++) begin
      rgo[k] = rgo[k-1] && !rrise[k-1];
    end
    for (int k = 1; k <= LEFT_REACH; k++) begin
      cand[k] = (lgo[k-1] && REACH_W'(k) <= slot.lcnt) ? win[LEFT_REACH-k] : '1;
    end
    for (int k = 1; k <= RIGHT_REACH; k++) begin
      cand[LEFT_REACH+k] = (rgo[k-1] && REACH_W'(k) <= slot.rcnt) ?
                           win[LEFT_REACH+k] : '1;
    end
    for (int i = 0; i < LVL1_N; i++) begin
      lvl1[i] = (2*i+1 < CAND_N) ? min2(cand[2*i], cand[2*i+1]) : cand[2*i];
    end
    s1_nxt.vld  = slot.vld;
    s1_nxt.mark = slot.mark;
    s1_nxt.lm   = slot.pok && (mag > win[LEFT_REACH-1]) && (mag > win[LEFT_REACH+1])
                  && (mag > cfg.thr);
    s1_nxt.bin  = slot.bin;
    s1_nxt.mag  = mag;
    for (int i = 0; i < LVL2_N; i++) begin
      s1_nxt.mins[i] = (2*i+1 < LVL1_N) ? min2(lvl1[2*i], lvl1[2*i+1]) : lvl1[2*i];
    end
  end

  // stage 2: rest of the tree and the floor test
  always_comb begin
    for (int i = 0; i < PAD_N; i++) begin
      pad[i] = '1;
    end
    for (int i = 0; i < LVL2_N; i++) begin
      pad[i] = s1_r.mins[i];
    end
    for (int i = 0; i < PAD_N/2; i++) begin
      t4[i] = min2(pad[2*i], pad[2*i+1]);
    end
    for (int i = 0; i < PAD_N/4; i++) begin
      t2[i] = min2(t4[2*i], t4[2*i+1]);
    end
    s2_nxt.vld    = s1_r.vld;
    s2_nxt.mark   = s1_r.mark;
    s2_nxt.bin    = s1_r.bin;
    s2_nxt.mag    = s1_r.mag;
    s2_nxt.valley = min2(t2[0], t2[1]);
    s2_nxt.ok     = s1_r.lm && (s2_nxt.valley > cfg.floor);
  end

  // stage 3: peak * 4096 >= ratio * valley
  assign prod = PROD_W'(cfg.ratio) * PROD_W'(s2_r.valley);
  assign lhs  = PROD_W'({s2_r.mag, {RATIO_FRAC{1'b0}}});
  assign pass = s2_r.ok && (lhs >= prod);
  assign push = s2_r.vld && (s2_r.mark || pass);

  always_comb begin
    if (s2_r.mark) begin
      push_data.is_peak        = 1'b0;
      push_data.bin_index      = '0;
      push_data.peak_magnitude = '0;
      push_data.frame_end      = 1'b1;
    end else begin
      push_data.is_peak        = 1'b1;
      push_data.bin_index      = s2_r.bin;
      push_data.peak_magnitude = s2_r.mag;
      push_data.frame_end      = 1'b0;
    end
  end

  assign jstat.s1_vld = s1_r.vld;
  assign jstat.s2_vld = s2_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

endmodule

@@ rtl/core/spp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Spectral peak picker result queue
// Small FIFO between the judge pipeline and the result channel.
// ----------------------------------------------------------------------------
module spp_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  spp_pkg::res_t             push_data,
  input  logic                      pop,
  output spp_pkg::res_t             head,
  output logic [spp_pkg::FIFO_CW-1:0] count
);
  import spp_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  assign head  = mem[rd_ptr_r];
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && count_r == FIFO_CW'(FIFO_DEPTH)))
    else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("result queue underflow");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == FIFO_AW'(rd_ptr_r + count_r[FIFO_AW-1:0]))
    else $error("result queue pointers out of step");
`endif

endmodule

@@ dv/spectral_peak_picker_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spectral peak picker testbench
// Streams framed magnitude bins through the unit under random handshake
// pressure. A local model of the picker predicts each peak report and frame
// end marker, and every delivered result is checked against those predictions.
// ----------------------------------------------------------------------------
module spectral_peak_picker_unit_tb;
  import spp_pkg::*;

  localparam int    SETTLE_CYCLES = 24;      // flush steps, marker plus judge pipe
  localparam int    HOLD_CYCLES   = 200;     // long result-side hold-off
  localparam time   RUN_LIMIT     = 3_000_000;

  // Directed frames: 1 bin, 2 bins, 3 bins with a floor-failing valley,
  // 3 bins with a clean peak, and a 12-bin frame with walks cut by rises.
  localparam int PROBE_N = 21;
  localparam logic [MAG_W-1:0] PROBE_MAG [PROBE_N] = '{
    24'hFFFFFF,
    24'd0, 24'hFFFFFF,
    24'd0, 24'hFFFFFF, 24'd0,
    24'd100, 24'd1000, 24'd100,
    24'd200, 24'd300, 24'd5000, 24'd300, 24'd200, 24'd250,
    24'd9000, 24'd100, 24'd150, 24'd20, 24'hFFFFFF, 24'd30
  };
  localparam logic [PROBE_N-1:0] PROBE_LAST = 21'h10_0125;

  typedef struct {
    logic [MAG_W-1:0] mag;
    logic             is_last;
  } bin_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [MAG_W-1:0]     in_magnitude = '0;
  logic                 in_last_bin  = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 out_is_peak;
  logic [BIN_W-1:0]     out_bin_index;
  logic [MAG_W-1:0]     out_peak_magnitude;
  logic                 out_frame_end;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  spectral_peak_picker_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_magnitude       (in_magnitude),
    .in_last_bin        (in_last_bin),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_peak        (out_is_peak),
    .out_bin_index      (out_bin_index),
    .out_peak_magnitude (out_peak_magnitude),
    .out_frame_end      (out_frame_end),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Picker model state: register shadows, bin history (newest last) and the
  // count of bins taken in the current frame, saturating at MAX_BINS.
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]   thr_reg   = RST_PEAK_THRESHOLD;
  logic [RATIO_W-1:0] ratio_reg = RST_PROM_RATIO;
  logic [MAG_W-1:0]   floor_reg = RST_VALLEY_FLOOR;
  logic [MAG_W-1:0]   bin_hist [WIN_DEPTH];
  int                 bin_cnt   = 0;

  bin_item_t bin_queue [$];        // bins waiting for the driver
  res_t      pending_reports [$];  // predicted results, oldest first
  int        items_queued = 0;
  int        items_taken  = 0;
  int        fault_count  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_token = 1'b0;    // toggled to request a long hold-off
  bit        hold_seen  = 1'b0;
  int        hold_left  = 0;

  initial begin
    foreach (bin_hist[i]) bin_hist[i] = '0;
  end

  // Decide bin p sitting at history slot pos, for a frame of n bins.
  function automatic bit peak_at(int pos, int p, int n);
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] low;
    logic [MAG_W-1:0] v;
    logic [63:0]      scaled;
    logic [63:0]      bar;
    int               k;
    if (p < 1 || p + 1 > n - 1 || pos < LEFT_REACH || pos > WIN_DEPTH - 2) return 1'b0;
    mag = bin_hist[pos];
    if (!(mag > bin_hist[pos-1] && mag > bin_hist[pos+1] && mag > thr_reg)) return 1'b0;
    low = mag;
    // left walk ends after the first bin that rises above its right neighbor
    for (k = 1; k <= LEFT_REACH; k++) begin
      if (p < k) break;
      v = bin_hist[pos-k];
      if (v < low) low = v;
      if (v > bin_hist[pos-k+1]) break;
    end
    // right walk, mirrored, never past the frame end or the newest bin
    for (k = 1; k <= RIGHT_REACH; k++) begin
      if (p + k >= n || pos + k >= WIN_DEPTH) break;
      v = bin_hist[pos+k];
      if (v < low) low = v;
      if (v > bin_hist[pos+k-1]) break;
    end
    if (!(low > floor_reg)) return 1'b0;
    scaled = 64'(mag) << RATIO_FRAC;
    bar    = 64'(ratio_reg) * 64'(low);
    return scaled >= bar;
  endfunction

  function automatic void add_report(logic peak, int p, logic [MAG_W-1:0] mag, logic fe);
    res_t r;
    r.is_peak        = peak;
    r.bin_index      = p[BIN_W-1:0];
    r.peak_magnitude = mag;
    r.frame_end      = fe;
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  // One accepted bin: shift it in, judge the bin RIGHT_REACH behind it, and on
  // the frame's last bin judge everything still open and add the end marker.
  function automatic void predict_bin(logic [MAG_W-1:0] mag, logic is_last);
    int newest;
    int p;
    int n;
    int pos;
    if (bin_cnt < MAX_BINS) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) bin_hist[i] = bin_hist[i+1];
      bin_hist[WIN_DEPTH-1] = mag;
      newest = bin_cnt;
      bin_cnt++;
      p = newest - RIGHT_REACH;
      if (peak_at(LEFT_REACH, p, bin_cnt + 1)) add_report(1'b1, p, bin_hist[LEFT_REACH], 1'b0);
    end
    if (is_last) begin
      n = bin_cnt;
      newest = n - 1;
      for (p = n - RIGHT_REACH; p <= n - 2; p++) begin
        if (p < 1) continue;
        pos = p - newest + WIN_DEPTH - 1;
        if (peak_at(pos, p, n)) add_report(1'b1, p, bin_hist[pos], 1'b0);
      end
      add_report(1'b0, 0, '0, 1'b1);
      foreach (bin_hist[i]) bin_hist[i] = '0;
      bin_cnt = 0;
    end
  endfunction

  function automatic void check_field(string name, logic [MAG_W-1:0] want,
                                      logic [MAG_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predicts on each accepted transaction, then offers the next bin
  // only when the current one is gone, so a stalled payload stays put.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bin_item_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_bin(in_magnitude, in_last_bin);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (bin_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = bin_queue.pop_front();
          in_valid     <= 1'b1;
          in_magnitude <= nxt.mag;
          in_last_bin  <= nxt.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction and
  // drives the result-side stall, including the long hold-off on request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("result with nothing predicted: is_peak %0d bin %0d mag 0x%0h frame_end %0d",
                 out_is_peak, out_bin_index, out_peak_magnitude, out_frame_end);
          fault_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("is_peak", MAG_W'(want.is_peak), MAG_W'(out_is_peak));
          check_field("bin_index", MAG_W'(want.bin_index), MAG_W'(out_bin_index));
          check_field("peak_magnitude", want.peak_magnitude, out_peak_magnitude);
          check_field("frame_end", MAG_W'(want.frame_end), MAG_W'(out_frame_end));
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_bin(logic [MAG_W-1:0] mag, logic is_last);
    bin_item_t it;
    it.mag     = mag;
    it.is_last = is_last;
    bin_queue.insert(bin_queue.size(), it);
    items_queued++;
  endtask

  // Mix of full-range values, values around the default threshold and floor,
  // small wiggles on the previous bin, and the two extremes.
  function automatic logic [MAG_W-1:0] rand_mag(logic [MAG_W-1:0] prev);
    logic [MAG_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = MAG_W'($urandom);
      4, 5, 6:    v = MAG_W'($urandom_range(255));
      7, 8:       v = prev ^ MAG_W'($urandom_range(63));
      default:    v = $urandom_range(1) ? '1 : '0;
    endcase
    return v;
  endfunction

  // Whole frames until about count bins are queued; short_frames keeps them
  // at a few bins so markers come often.
  task automatic queue_frames(int count, bit short_frames);
    int remaining;
    int len;
    logic [MAG_W-1:0] m;
    remaining = count;
    while (remaining > 0) begin
      if ($urandom_range(7) == 0)                      len = $urandom_range(3, 1);
      else if (short_frames)                           len = $urandom_range(5, 4);
      else if ($urandom_range(9) == 0)                 len = $urandom_range(80, 30);
      else                                             len = $urandom_range(24, 4);
      m = '0;
      for (int i = 0; i < len; i++) begin
        m = rand_mag(m);
        queue_bin(m, i == len - 1);
      end
      remaining -= len;
    end
  endtask

  // Register write; cfg_valid stays up across back-to-back writes and is
  // dropped by the caller once the batch is done.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PEAK_THRESHOLD: thr_reg   = val[MAG_W-1:0];
      CFG_PROM_RATIO:     ratio_reg = val[RATIO_W-1:0];
      CFG_VALLEY_FLOOR:   floor_reg = val[MAG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [MAG_W-1:0] thr, logic [RATIO_W-1:0] ratio,
                           logic [MAG_W-1:0] flr);
    write_reg(CFG_PEAK_THRESHOLD, thr);
    write_reg(CFG_PROM_RATIO, CFG_DATA_W'(ratio));
    write_reg(CFG_VALLEY_FLOOR, flr);
    cfg_valid <= 1'b0;
  endtask

  // Sender pause: every queued bin taken and every predicted result seen,
  // then time for a flush that may still be producing nothing.
  task automatic wait_drained();
    do @(posedge clk);
    while (items_taken != items_queued || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames under the reset register values
    send_idle_pct = 36;
    recv_idle_pct = 78;
    for (int i = 0; i < PROBE_N; i++) queue_bin(PROBE_MAG[i], PROBE_LAST[i]);
    wait_drained();

    // loose ratio, floor at zero
    load_regs(MAG_W'($urandom_range(300)), 16'd4096, '0);
    queue_frames(70, 1'b0);
    wait_drained();

    // strictest ratio, idling swapped
    send_idle_pct = 78;
    recv_idle_pct = 36;
    load_regs('0, 16'hFFFF, MAG_W'($urandom_range(300)));
    queue_frames(65, 1'b0);
    wait_drained();

    // mid-range settings, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_regs(MAG_W'($urandom_range(65535)), RATIO_W'($urandom_range(16384, 4096)),
              MAG_W'($urandom_range(1000)));
    queue_frames(40, 1'b0);
    wait_drained();

    // result side held off while bins keep coming: queue and pipe fill up
    load_regs('0, 16'd4096, '0);
    hold_token <= ~hold_token;
    queue_frames(40, 1'b1);
    wait_drained();

    // threshold and floor at the top: only frame end markers
    load_regs('1, 16'd4096, '1);
    queue_frames(12, 1'b1);
    wait_drained();

    if (fault_count == 0) begin
      $display("spectral_peak_picker_unit_tb: done, clean");
    end else begin
      $display("spectral_peak_picker_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("spectral_peak_picker_unit_tb: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/spp_pkg.sv
rtl/core/spp_window.sv
rtl/core/spp_judge.sv
rtl/core/spp_out_fifo.sv
rtl/core/spectral_peak_picker_unit.sv
dv/spectral_peak_picker_unit_tb.sv
